FILE: rtl/tblf_pkg.sv
// ----------------------------------------------------------------------------
// tblf_pkg
// shared types, constants and helpers of the background line fetcher
// ----------------------------------------------------------------------------
package tblf_pkg;

    // video memory geometry
    localparam int VRAM_BYTES     = 8192;
    localparam int VRAM_ADDR_W    = $clog2(VRAM_BYTES);
    localparam int VRAM_DATA_W    = 8;

    // screen tiles per scanline
    localparam int TILES_PER_LINE = 20;

    // address map
    localparam logic [VRAM_ADDR_W-1:0] MAP_BASE_LOW     = 13'h1800;
    localparam logic [VRAM_ADDR_W-1:0] MAP_BASE_HIGH    = 13'h1C00;
    localparam logic [VRAM_ADDR_W-1:0] SIGNED_DATA_BASE = 13'h0800;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCROLL_X    = 2'd0,
        CFG_SCROLL_Y    = 2'd1,
        CFG_MAP_SELECT  = 2'd2,
        CFG_DATA_SELECT = 2'd3
    } t_cfg_index;

    // input item modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [VRAM_ADDR_W-1:0] vram_address;
        logic [7:0]             write_data;
        logic [7:0]             line;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  tile_column;
        logic [15:0] pixels;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_LO,
        S_HI,
        S_PIX
    } t_state;

    // byte address of one pixel row (low plane) of a tile
    function automatic logic [VRAM_ADDR_W-1:0] tile_row_addr(
        input logic [7:0] entry,
        input logic [2:0] prow,
        input logic       dsel
    );
        logic [VRAM_ADDR_W-1:0] row_off;
        row_off = {{(VRAM_ADDR_W-4){1'b0}}, prow, 1'b0};
        if (dsel) begin
            // signed index, biased into 0x0800..0x17ff
            tile_row_addr = SIGNED_DATA_BASE + {1'b0, entry ^ 8'h80, 4'b0000} + row_off;
        end else begin
            tile_row_addr = {1'b0, entry, 4'b0000} + row_off;
        end
    endfunction

    // merge two bit planes into eight 2-bit colour indices, leftmost first
    function automatic logic [15:0] interleave_planes(
        input logic [7:0] lo,
        input logic [7:0] hi
    );
        logic [15:0] res;
        res = '0;
        for (int b = 0; b < 8; b++) begin
            res[2*b]   = lo[b];
            res[2*b+1] = hi[b];
        end
        interleave_planes = res;
    endfunction

endpackage

FILE: rtl/tblf_ram.sv
// ----------------------------------------------------------------------------
// tblf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tblf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tile_background_line_fetcher.sv
// ----------------------------------------------------------------------------
// tile_background_line_fetcher
// background tile fetch of one scanline out of an 8 KiB video memory
//
// A write item stores one byte in video memory in the cycle it is accepted
// and gives no result. A render item walks the visible tiles of its
// scanline: for each tile the fetcher reads the map entry, then the low and
// the high bit plane of the pixel row, all from the single read port of the
// video memory, and loads the merged pixels into the output register. That
// read chain runs through a map, a low plane, a high plane and a result
// state for each of the 20 tiles, and the result state waits while the
// output side stalls. Items are taken only while no scanline is in progress.
// The memory holds no reset value: a byte must be written before a render
// reads it. Configuration is written through its own port; the user must
// write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module tile_background_line_fetcher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tblf_pkg::t_in_item  i_in,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tblf_pkg::t_out_item o_out
);

    import tblf_pkg::*;

    // configuration registers
    logic [7:0] r_scroll_x;
    logic [7:0] r_scroll_y;
    logic       r_map_sel;
    logic       r_data_sel;

    // sequencer state
    t_state                 r_state, n_state;
    logic [4:0]             r_tile, n_tile;
    logic [4:0]             r_col, n_col;
    logic [4:0]             r_map_row, n_map_row;
    logic [2:0]             r_prow, n_prow;
    logic [VRAM_ADDR_W-1:0] r_addr, n_addr;
    logic [7:0]             r_lo, n_lo;

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // memory signals
    logic                   ram_we;
    logic [VRAM_ADDR_W-1:0] ram_raddr;
    logic [VRAM_DATA_W-1:0] ram_rdata;

    logic                   in_acc;
    logic [7:0]             ypos;
    logic [VRAM_ADDR_W-1:0] map_base;
    logic                   out_load;
    logic                   tile_last;

    tblf_ram #(
        .DATA_W (VRAM_DATA_W),
        .DEPTH  (VRAM_BYTES)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in.vram_address),
        .i_wdata (i_in.write_data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_map_sel  <= 1'b0;
            r_data_sel <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SCROLL_X:    r_scroll_x <= i_cfg_data;
                CFG_SCROLL_Y:    r_scroll_y <= i_cfg_data;
                CFG_MAP_SELECT:  r_map_sel  <= i_cfg_data[0];
                CFG_DATA_SELECT: r_data_sel <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign ram_we     = in_acc && (i_in.mode == MODE_WRITE);
    assign ypos       = r_scroll_y + i_in.line;
    assign map_base   = r_map_sel ? MAP_BASE_HIGH : MAP_BASE_LOW;
    assign out_load   = !r_out_valid || i_out_ready;
    assign tile_last  = (r_tile == 5'(TILES_PER_LINE - 1));

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tile    <= n_tile;
        r_col     <= n_col;
        r_map_row <= n_map_row;
        r_prow    <= n_prow;
        r_addr    <= n_addr;
        r_lo      <= n_lo;
        r_out     <= n_out;
    end

    // sequencer: map read, low plane read, high plane read, result
    always_comb begin
        n_state     = r_state;
        n_tile      = r_tile;
        n_col       = r_col;
        n_map_row   = r_map_row;
        n_prow      = r_prow;
        n_addr      = r_addr;
        n_lo        = r_lo;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.mode == MODE_RENDER)) begin
                    n_tile    = '0;
                    n_col     = r_scroll_x[7:3];
                    n_map_row = ypos[7:3];
                    n_prow    = ypos[2:0];
                    n_state   = S_MAP;
                end
            end
            S_MAP: begin
                // tile map entry of the current column
                ram_raddr = map_base + {{(VRAM_ADDR_W-10){1'b0}}, r_map_row, r_col};
                n_state   = S_LO;
            end
            S_LO: begin
                // map entry arrives, fetch low plane
                ram_raddr = tile_row_addr(ram_rdata, r_prow, r_data_sel);
                n_addr    = ram_raddr;
                n_state   = S_HI;
            end
            S_HI: begin
                // low plane arrives, fetch high plane
                n_lo      = ram_rdata;
                ram_raddr = {r_addr[VRAM_ADDR_W-1:1], 1'b1};
                n_state   = S_PIX;
            end
            S_PIX: begin
                // high plane arrives, hold the read until the output slot frees
                ram_raddr = {r_addr[VRAM_ADDR_W-1:1], 1'b1};
                if (out_load) begin
                    n_out_valid       = 1'b1;
                    n_out.tile_column = r_tile;
                    n_out.pixels      = interleave_planes(r_lo, ram_rdata);
                    n_out.last        = tile_last;
                    n_tile            = r_tile + 5'd1;
                    n_col             = r_col + 5'd1;
                    n_state           = tile_last ? S_IDLE : S_MAP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // no memory write while a scanline is being fetched
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !ram_we)
        else $error("video memory written during a fetch");

    // the last flag sits on the final screen tile only
    a_last_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last == (o_out.tile_column == 5'(TILES_PER_LINE - 1))))
        else $error("last flag and tile column disagree");

    // a render item starts the walk at screen tile zero
    a_render_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.mode == MODE_RENDER)) |=> (r_state == S_MAP) && (r_tile == 5'd0))
        else $error("render did not start at the first tile");

endmodule
